/* design/hsv_to_rgb_converter_unit_macros.svh */
// assertion macros shared by the hsv to rgb converter rtl
`ifndef HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH

// same-cycle implication, checked on clk with reset as disable
`define HSVRGB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk with reset as disable
`define HSVRGB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/hsvrgb_pkg.sv */
// types and constants of the hsv to rgb converter
`default_nettype none

package hsvrgb_pkg;

  localparam int unsigned HUE_W       = 17;
  localparam int unsigned LVL_W       = 16;
  localparam int unsigned REM_W       = 14;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned RECIP_W     = 21;
  localparam int unsigned RECIP_SHIFT = 18;
  localparam int unsigned MAX_WHOLE   = 8;

  // sixty degrees in hue units
  localparam logic [HUE_W-1:0]   SECTOR_SPAN = 17'd15360;
  localparam logic [LVL_W-1:0]   ONE_Q15     = 16'd32768;
  localparam logic [FRAC_W:0]    ONE_Q16     = 17'd65536;
  // ceil(2^24 / 15), exact for rem * 64 / 15 over the whole remainder range
  localparam logic [RECIP_W-1:0] RECIP_15    = 21'd1118482;
  localparam logic [3:0]         SECTORS     = 4'd6;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_t;

endpackage

`default_nettype wire

/* design/hsvrgb_hue_split.sv */
// splits a hue angle into its colour sector and the remainder within it
`default_nettype none

module hsvrgb_hue_split
  import hsvrgb_pkg::*;
(
  input  logic [HUE_W-1:0] hue,
  output sector_t          sector,
  output logic [REM_W-1:0] rem
);

  logic [3:0]       whole;
  logic [HUE_W-1:0] base;
  logic [3:0]       wrapped;

  // quotient by sixty degrees from a row of constant compares
  always_comb begin
    whole = '0;
    for (int k = 1; k <= MAX_WHOLE; k++) begin
      if (hue >= HUE_W'(k) * SECTOR_SPAN) whole = 4'(k);
    end
  end

  assign base    = HUE_W'(whole) * SECTOR_SPAN;
  assign rem     = REM_W'(hue - base);
  // hues past a full turn wrap round
  assign wrapped = (whole >= SECTORS) ? (whole - SECTORS) : whole;
  assign sector  = sector_t'(wrapped[2:0]);

endmodule

`default_nettype wire

/* design/hsv_to_rgb_converter_unit.sv */
// hsv to rgb converter: one pixel per clock, six-sector rule in fixed point
// an accepted beat passes stages s1, s2, s3, s4 and the output register before it is strobed on the out_ ports
// throughput: one beat every clock; busy stays low once out of reset
// nothing loops back, so each of the five register stages takes a new beat every clock
// reset (synchronous, active low) clears all stage valid bits and holds busy high
// results are strobed for one cycle; the receiver cannot stall
`default_nettype none
`include "hsv_to_rgb_converter_unit_macros.svh"

module hsv_to_rgb_converter_unit
  import hsvrgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [HUE_W-1:0] in_hue_angle,
  input  logic [LVL_W-1:0] in_sat_level,
  input  logic [LVL_W-1:0] in_val_level,
  output logic             out_strobe,
  output logic [LVL_W-1:0] out_red_level,
  output logic [LVL_W-1:0] out_green_level,
  output logic [LVL_W-1:0] out_blue_level
);

  function automatic logic [LVL_W-1:0] clamp_unit(input logic [LVL_W-1:0] x);
    return (x > ONE_Q15) ? ONE_Q15 : x;
  endfunction

  logic accept;
  logic busy_r;

  sector_t          split_sector;
  logic [REM_W-1:0] split_rem;

  // stage 1: sector, remainder, clamped levels
  logic             s1_valid_r;
  sector_t          s1_sector_r;
  logic [REM_W-1:0] s1_rem_r;
  logic [LVL_W-1:0] s1_sat_r, s1_val_r;

  // stage 2: fraction and p
  logic                     s2_valid_r;
  sector_t                  s2_sector_r;
  logic [FRAC_W-1:0]        s2_frac_r, s2_frac_nxt;
  logic [LVL_W-1:0]         s2_sat_r, s2_val_r, s2_p_r, s2_p_nxt;
  logic [REM_W+RECIP_W-1:0] frac_prod;
  logic [2*LVL_W-1:0]       p_prod;

  // stage 3: f*s and (1-f)*s
  logic                  s3_valid_r;
  sector_t               s3_sector_r;
  logic [LVL_W-1:0]      s3_sat_r, s3_val_r, s3_p_r;
  logic [LVL_W-1:0]      s3_fs_r, s3_fs_nxt, s3_gs_r, s3_gs_nxt;
  logic [FRAC_W:0]       frac_compl;
  logic [FRAC_W+LVL_W-1:0] fs_prod;
  logic [FRAC_W+LVL_W:0]   gs_prod;

  // stage 4: q and t
  logic               s4_valid_r;
  sector_t            s4_sector_r;
  logic [LVL_W-1:0]   s4_val_r, s4_p_r;
  logic [LVL_W-1:0]   s4_q_r, s4_q_nxt, s4_t_r, s4_t_nxt;
  logic [2*LVL_W-1:0] q_prod, t_prod;

  // stage 5: output register
  logic             out_valid_r;
  logic [LVL_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic [LVL_W-1:0] out_red_nxt, out_green_nxt, out_blue_nxt;

  assign accept = start && !busy_r;

  hsvrgb_hue_split u_hue_split (
    .hue    (in_hue_angle),
    .sector (split_sector),
    .rem    (split_rem)
  );

  always_comb begin
    // f = rem * 65536 / 15360 = rem * 64 / 15
    frac_prod   = (REM_W+RECIP_W)'(s1_rem_r) * (REM_W+RECIP_W)'(RECIP_15);
    s2_frac_nxt = frac_prod[FRAC_W+RECIP_SHIFT-1:RECIP_SHIFT];
    p_prod      = (2*LVL_W)'(s1_val_r) * (2*LVL_W)'(ONE_Q15 - s1_sat_r);
    s2_p_nxt    = p_prod[2*LVL_W-2:LVL_W-1];

    fs_prod    = (FRAC_W+LVL_W)'(s2_frac_r) * (FRAC_W+LVL_W)'(s2_sat_r);
    s3_fs_nxt  = fs_prod[FRAC_W+LVL_W-1:FRAC_W];
    frac_compl = ONE_Q16 - (FRAC_W+1)'(s2_frac_r);
    gs_prod    = (FRAC_W+LVL_W+1)'(frac_compl) * (FRAC_W+LVL_W+1)'(s2_sat_r);
    // (1-f)*s never exceeds one, so the top bit is clear
    s3_gs_nxt  = gs_prod[FRAC_W+LVL_W-1:FRAC_W];

    q_prod   = (2*LVL_W)'(s3_val_r) * (2*LVL_W)'(ONE_Q15 - s3_fs_r);
    s4_q_nxt = q_prod[2*LVL_W-2:LVL_W-1];
    t_prod   = (2*LVL_W)'(s3_val_r) * (2*LVL_W)'(ONE_Q15 - s3_gs_r);
    s4_t_nxt = t_prod[2*LVL_W-2:LVL_W-1];
  end

  always_comb begin
    case (s4_sector_r)
      SEC_RED_YELLOW: begin
        out_red_nxt = s4_val_r; out_green_nxt = s4_t_r;   out_blue_nxt = s4_p_r;
      end
      SEC_YELLOW_GREEN: begin
        out_red_nxt = s4_q_r;   out_green_nxt = s4_val_r; out_blue_nxt = s4_p_r;
      end
      SEC_GREEN_CYAN: begin
        out_red_nxt = s4_p_r;   out_green_nxt = s4_val_r; out_blue_nxt = s4_t_r;
      end
      SEC_CYAN_BLUE: begin
        out_red_nxt = s4_p_r;   out_green_nxt = s4_q_r;   out_blue_nxt = s4_val_r;
      end
      SEC_BLUE_MAGENTA: begin
        out_red_nxt = s4_t_r;   out_green_nxt = s4_p_r;   out_blue_nxt = s4_val_r;
      end
      default: begin
        out_red_nxt = s4_val_r; out_green_nxt = s4_p_r;   out_blue_nxt = s4_q_r;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    s1_sector_r <= split_sector;
    s1_rem_r    <= split_rem;
    s1_sat_r    <= clamp_unit(in_sat_level);
    s1_val_r    <= clamp_unit(in_val_level);

    s2_sector_r <= s1_sector_r;
    s2_frac_r   <= s2_frac_nxt;
    s2_sat_r    <= s1_sat_r;
    s2_val_r    <= s1_val_r;
    s2_p_r      <= s2_p_nxt;

    s3_sector_r <= s2_sector_r;
    s3_sat_r    <= s2_sat_r;
    s3_val_r    <= s2_val_r;
    s3_p_r      <= s2_p_r;
    s3_fs_r     <= s3_fs_nxt;
    s3_gs_r     <= s3_gs_nxt;

    s4_sector_r <= s3_sector_r;
    s4_val_r    <= s3_val_r;
    s4_p_r      <= s3_p_r;
    s4_q_r      <= s4_q_nxt;
    s4_t_r      <= s4_t_nxt;

    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
  end

  assign busy            = busy_r;
  assign out_strobe      = out_valid_r;
  assign out_red_level   = out_red_r;
  assign out_green_level = out_green_r;
  assign out_blue_level  = out_blue_r;

  `HSVRGB_ASSERT_IMP(a_latency, accept, ##5 out_strobe, "accepted beat not strobed out after five cycles")
  `HSVRGB_ASSERT_NXT(a_fs_gs_sum, s2_valid_r, (17'(s3_fs_r) + 17'(s3_gs_r) == 17'(s3_sat_r)) || (17'(s3_fs_r) + 17'(s3_gs_r) + 17'd1 == 17'(s3_sat_r)), "f*s and (1-f)*s do not add up to saturation")
  `HSVRGB_ASSERT_NXT(a_value_routed, s4_valid_r, (out_red_r == $past(s4_val_r)) || (out_green_r == $past(s4_val_r)) || (out_blue_r == $past(s4_val_r)), "value not routed to any output")
  `HSVRGB_ASSERT_IMP(a_out_range, out_strobe, (out_red_r <= ONE_Q15) && (out_green_r <= ONE_Q15) && (out_blue_r <= ONE_Q15), "output level above one")

endmodule

`default_nettype wire
